// ===== src/bdl_pkg.sv =====
// Shared constants and types for the bounded double-ended queue.
`default_nettype none

package bdl_pkg;

  localparam int unsigned CapacityDefault  = 256;
  localparam int unsigned ElemWidthDefault = 32;
  localparam int unsigned KindWidth        = 3;
  localparam int unsigned IndexWidth       = 8;
  localparam int unsigned OutWidth         = 32;

  typedef enum logic [KindWidth-1:0] {
    KIND_READ      = 3'd0,
    KIND_PUSH_HEAD = 3'd1,
    KIND_PUSH_TAIL = 3'd2,
    KIND_POP_HEAD  = 3'd3,
    KIND_POP_TAIL  = 3'd4
  } kind_e;

  typedef struct packed {
    logic push_head;
    logic push_tail;
    logic pop_head;
  } op_t;

endpackage

`default_nettype wire

// ===== src/bdl_cell.sv =====
// One storage cell of the queue chain with its slices of the tail and index read buses.
`default_nettype none

module bdl_cell #(
  parameter int unsigned ELEMENT_WIDTH = bdl_pkg::ElemWidthDefault,
  parameter int unsigned CNT_W         = $clog2(bdl_pkg::CapacityDefault + 1),
  parameter int unsigned POS           = 0
) (
  input  wire                                 clk_i,
  input  bdl_pkg::op_t                        op_i,
  input  wire [ELEMENT_WIDTH-1:0]             new_elem_i,
  input  wire [ELEMENT_WIDTH-1:0]             left_i,
  input  wire [ELEMENT_WIDTH-1:0]             right_i,
  input  wire [CNT_W-1:0]                     count_i,
  input  wire [bdl_pkg::IndexWidth-1:0]       idx_i,
  input  wire                                 idx_valid_i,
  input  wire [ELEMENT_WIDTH-1:0]             tail_acc_i,
  input  wire [ELEMENT_WIDTH-1:0]             idx_acc_i,
  output logic [ELEMENT_WIDTH-1:0]            data_o,
  output logic [ELEMENT_WIDTH-1:0]            tail_acc_o,
  output logic [ELEMENT_WIDTH-1:0]            idx_acc_o
);
  import bdl_pkg::*;

  localparam int unsigned CmpW = (CNT_W > IndexWidth) ? CNT_W : IndexWidth;

  logic [ELEMENT_WIDTH-1:0] data_q, data_d;
  logic [ELEMENT_WIDTH-1:0] tail_acc_q, idx_acc_q;
  logic                     tail_hit, idx_hit;

  always_comb begin
    data_d = data_q;
    if (op_i.push_head) begin
      data_d = left_i;
    end else if (op_i.pop_head) begin
      data_d = right_i;
    end else if (op_i.push_tail && (count_i == CNT_W'(POS))) begin
      data_d = new_elem_i;
    end
  end

  assign tail_hit = (count_i == CNT_W'(POS + 1));
  assign idx_hit  = idx_valid_i && (CmpW'(idx_i) == CmpW'(POS));

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    tail_acc_q <= tail_acc_i | ({ELEMENT_WIDTH{tail_hit}} & data_q);
    idx_acc_q  <= idx_acc_i | ({ELEMENT_WIDTH{idx_hit}} & data_q);
  end

  assign data_o     = data_q;
  assign tail_acc_o = tail_acc_q;
  assign idx_acc_o  = idx_acc_q;

endmodule

`default_nettype wire

// ===== src/bounded_deque_list_top.sv =====
// Top level of the bounded double-ended queue built as a shifting chain of cells.
// An accepted word updates the chain at its accept edge; its result strobe rises when the sweep ends.
// The tail and indexed reads ripple through the CAPACITY cells, one cell per cycle.
// A new word can be taken in the strobe cycle; no new word is taken while the last one is busy.
// Reset clears the count, busy, strobe and refusal state at once; stored words stay undefined until written.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module bounded_deque_list_top #(
  parameter int unsigned CAPACITY      = bdl_pkg::CapacityDefault,
  parameter int unsigned ELEMENT_WIDTH = bdl_pkg::ElemWidthDefault
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start,
  output logic                                busy,
  output logic                                done_o,
  input  wire [bdl_pkg::KindWidth-1:0]        kind_i,
  input  wire [31:0]                          new_element_i,
  input  wire [bdl_pkg::IndexWidth-1:0]       read_index_i,
  output logic [$clog2(CAPACITY + 1)-1:0]     element_count_o,
  output logic                                list_full_o,
  output logic                                list_empty_o,
  output logic [bdl_pkg::OutWidth-1:0]        head_element_o,
  output logic [bdl_pkg::OutWidth-1:0]        tail_element_o,
  output logic [bdl_pkg::OutWidth-1:0]        indexed_element_o,
  output logic                                index_valid_o,
  output logic                                op_refused_o
);
  import bdl_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned SwW  = $clog2(CAPACITY);
  localparam int unsigned CmpW = (CntW > IndexWidth) ? CntW : IndexWidth;

  logic                     accept;
  logic                     is_push, is_pop, full, empty, refuse;
  op_t                      op;
  logic [ELEMENT_WIDTH-1:0] new_word;

  logic [CntW-1:0]          count_q, count_d;
  logic                     busy_q, done_q, refused_q;
  logic [SwW-1:0]           sweep_q;
  logic [IndexWidth-1:0]    idx_q;
  logic                     idx_valid;

  logic [ELEMENT_WIDTH-1:0] data_w     [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] left_w     [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] right_w    [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] tail_acc_w [CAPACITY+1];
  logic [ELEMENT_WIDTH-1:0] idx_acc_w  [CAPACITY+1];

  assign accept   = start && !busy_q;
  assign new_word = ELEMENT_WIDTH'(new_element_i);
  assign full     = (count_q == CntW'(CAPACITY));
  assign empty    = (count_q == '0);
  assign is_push  = (kind_i == KIND_PUSH_HEAD) || (kind_i == KIND_PUSH_TAIL);
  assign is_pop   = (kind_i == KIND_POP_HEAD) || (kind_i == KIND_POP_TAIL);
  assign refuse   = (is_push && full) || (is_pop && empty);

  assign op.push_head = accept && (kind_i == KIND_PUSH_HEAD) && !full;
  assign op.push_tail = accept && (kind_i == KIND_PUSH_TAIL) && !full;
  assign op.pop_head  = accept && (kind_i == KIND_POP_HEAD) && !empty;

  always_comb begin
    count_d = count_q;
    if (accept && is_push && !full) begin
      count_d = count_q + CntW'(1);
    end else if (accept && is_pop && !empty) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      sweep_q   <= '0;
      refused_q <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= 1'b0;
      if (accept) begin
        busy_q    <= 1'b1;
        sweep_q   <= '0;
        refused_q <= refuse;
      end else if (busy_q) begin
        if (sweep_q == SwW'(CAPACITY - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          sweep_q <= sweep_q + SwW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= read_index_i;
    end
  end

  assign idx_valid = (CmpW'(idx_q) < CmpW'(count_q));

  assign left_w[0]            = new_word;
  assign tail_acc_w[CAPACITY] = '0;
  assign idx_acc_w[CAPACITY]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i > 0) begin : g_left
      assign left_w[i] = data_w[i-1];
    end
    if (i < CAPACITY - 1) begin : g_right
      assign right_w[i] = data_w[i+1];
    end else begin : g_last
      assign right_w[i] = data_w[i];
    end

    bdl_cell #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .CNT_W         (CntW),
      .POS           (i)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .new_elem_i  (new_word),
      .left_i      (left_w[i]),
      .right_i     (right_w[i]),
      .count_i     (count_q),
      .idx_i       (idx_q),
      .idx_valid_i (idx_valid),
      .tail_acc_i  (tail_acc_w[i+1]),
      .idx_acc_i   (idx_acc_w[i+1]),
      .data_o      (data_w[i]),
      .tail_acc_o  (tail_acc_w[i]),
      .idx_acc_o   (idx_acc_w[i])
    );
  end

  assign busy              = busy_q;
  assign done_o            = done_q;
  assign element_count_o   = count_q;
  assign list_full_o       = full;
  assign list_empty_o      = empty;
  assign head_element_o    = empty ? '0 : OutWidth'(data_w[0]);
  assign tail_element_o    = OutWidth'(tail_acc_w[0]);
  assign indexed_element_o = OutWidth'(idx_acc_w[0]);
  assign index_valid_o     = idx_valid;
  assign op_refused_o      = refused_q;

endmodule

`default_nettype wire

// ===== src/bdl_checker.sv =====
// Port-level checks for the queue top level and the bind that attaches them.
`default_nettype none

module bdl_checker #(
  parameter int unsigned CAPACITY = bdl_pkg::CapacityDefault
) (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             start,
  input wire                             busy,
  input wire                             done_o,
  input wire [$clog2(CAPACITY + 1)-1:0]  element_count_o
);
  import bdl_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Accepted word did not raise busy.");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("Result strobe while busy.");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe lasted more than one cycle.");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !($past(start) && !$past(busy)) |-> $stable(element_count_o))
    else $error("Element count changed without an accepted word.");

endmodule

bind bounded_deque_list_top bdl_checker #(
  .CAPACITY (CAPACITY)
) u_bdl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .element_count_o (element_count_o)
);

`default_nettype wire
